// ===== rtl/core/stos_pkg.sv =====
// stos_pkg: shared types and codes for the start-time ordered stack.
// Used by stos_cell and start_time_ordered_stack; no dependencies.
package stos_pkg;

  // Operation codes carried on the input transaction
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_PUSH   = 2'd1,
    OP_POP    = 2'd2,
    OP_PEEK   = 2'd3
  } op_t;

  // Command broadcast to every cell in the row
  typedef enum logic [1:0] {
    CMD_HOLD   = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_PUSH   = 2'd2,
    CMD_POP    = 2'd3
  } cmd_t;

  // One stored entry
  typedef struct packed {
    logic [15:0] pid;
    logic [15:0] start_time;
  } entry_t;

  // Control bundle shared by all cells
  typedef struct packed {
    cmd_t   cmd;
    entry_t new_entry;
  } cell_ctrl_t;

endpackage

// ===== rtl/core/start_time_ordered_stack.sv =====
// start_time_ordered_stack: top level, a row of stos_cell slots with a fill count
// and a registered result. Depends on stos_pkg and stos_cell.
//
// A bounded stack of (pid, start_time) entries held in a row of DEPTH cells with
// the top in cell 0. Each input transaction (ordered insert, push, pop or peek)
// yields exactly one result transaction, registered and presented the cycle after
// acceptance; a new transaction is taken every cycle as long as the result register
// is free or being emptied in that same cycle. The cycle time is set by the insert
// scan: every cell compares its start time with the new key at once, and the
// keep/shift decision ripples from cell 0 down the row, so that path grows with
// DEPTH. Entries beyond the fill count are never read, and an empty stack reports
// a top of zero.
module start_time_ordered_stack #(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  operation,
  input  logic [15:0] pid,
  input  logic [15:0] start_time,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] top_pid,
  output logic [15:0] top_start_time,
  output logic        is_empty,
  output logic [4:0]  entry_count,
  output logic        overflow
);
  import stos_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0] count, count_next;
  logic          accept, full, empty, dropped;
  cell_ctrl_t    ctrl;
  entry_t        cell_q   [DEPTH];
  entry_t        cell_d   [DEPTH];
  logic          pass     [DEPTH+1];
  op_t           op;

  assign op       = op_t'(operation);
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;
  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);

  // Decode the transaction into a row command and the next fill count
  always_comb begin
    ctrl.new_entry.pid        = pid;
    ctrl.new_entry.start_time = start_time;
    ctrl.cmd   = CMD_HOLD;
    count_next = count;
    dropped    = 1'b0;
    if (accept) begin
      case (op)
        OP_INSERT, OP_PUSH: begin
          if (full) begin
            dropped = 1'b1;
          end else begin
            ctrl.cmd   = (op == OP_INSERT) ? CMD_INSERT : CMD_PUSH;
            count_next = count + 1'b1;
          end
        end
        OP_POP: begin
          if (!empty) begin
            ctrl.cmd   = CMD_POP;
            count_next = count - 1'b1;
          end
        end
        default: ctrl.cmd = CMD_HOLD;
      endcase
    end
  end

  // Row of cells, top at index 0
  assign pass[0] = 1'b1;

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    entry_t above, below;
    logic   occ;

    assign occ = (count > CW'(k));

    if (k == 0) begin : g_first
      assign above = '0;
    end else begin : g_mid
      assign above = cell_q[k-1];
    end

    if (k == DEPTH - 1) begin : g_last
      assign below = '0;
    end else begin : g_inner
      assign below = cell_q[k+1];
    end

    stos_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .occupied    (occ),
      .pass_in     (pass[k]),
      .above_entry (above),
      .below_entry (below),
      .pass_out    (pass[k+1]),
      .entry       (cell_q[k]),
      .entry_next  (cell_d[k])
    );
  end

  // Fill count and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      if (count_next == '0) begin
        top_pid        <= '0;
        top_start_time <= '0;
      end else begin
        top_pid        <= cell_d[0].pid;
        top_start_time <= cell_d[0].start_time;
      end
      is_empty    <= (count_next == '0);
      entry_count <= 5'(count_next);
      overflow    <= dropped;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("fill count above depth");

  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && overflow |-> full)
    else $error("overflow reported while not full");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_empty |-> (top_pid == '0) && (top_start_time == '0))
    else $error("empty stack reports nonzero top");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    accept && (op == OP_PUSH) && !full |=> count == $past(count) + 1'b1)
    else $error("push did not grow the stack");

  a_push_top: assert property (@(posedge clk) disable iff (rst)
    accept && (op == OP_PUSH) && !full |=> out_valid && (top_pid == $past(pid)))
    else $error("pushed entry not on top");
`endif

endmodule

// ===== rtl/core/stos_cell.sv =====
// stos_cell: one slot of the ordered stack; cell 0 is the top.
// Depends on stos_pkg for the entry and control types.
module stos_cell (
  input  logic                clk,
  input  stos_pkg::cell_ctrl_t ctrl,
  input  logic                occupied,    // slot is below the fill count
  input  logic                pass_in,     // insert scan: every cell above kept its entry
  input  stos_pkg::entry_t    above_entry, // entry of the neighbor toward the top
  input  stos_pkg::entry_t    below_entry, // entry of the neighbor toward the bottom
  output logic                pass_out,
  output stos_pkg::entry_t    entry,
  output stos_pkg::entry_t    entry_next
);
  import stos_pkg::*;

  logic later;  // stored start time is later than the new one

  // Compare against the broadcast key
  assign later = occupied && (entry.start_time > ctrl.new_entry.start_time);

  // Scan continues downward only for an insert past an earlier-or-equal entry
  assign pass_out = (ctrl.cmd == CMD_INSERT) && pass_in && occupied && !later;

  // Slot update: keep, load the new entry, or shift from a neighbor
  always_comb begin
    case (ctrl.cmd)
      CMD_INSERT, CMD_PUSH: begin
        if (pass_in) begin
          if ((ctrl.cmd == CMD_INSERT) && occupied && !later) begin
            entry_next = entry;
          end else begin
            entry_next = ctrl.new_entry;
          end
        end else begin
          entry_next = above_entry;
        end
      end
      CMD_POP:  entry_next = below_entry;
      default:  entry_next = entry;
    endcase
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule
